### rtl/spdl_pkg.sv
`timescale 1ns / 1ps
// Shared constants, register indexes, opcodes and controller/datapath
// command and status types for the stereo propagation delay line.
package spdl_pkg;

    // Ring depth in samples; a power of two so that ring addresses are low counter bits.
    localparam int MAX_DELAY   = 4096;
    localparam int SAMPLE_BITS = 16;
    localparam int DELAY_BITS  = $clog2(MAX_DELAY);
    localparam int RING_AW     = $clog2(MAX_DELAY);
    localparam int CNT_BITS    = 32;

    localparam int OFF_BITS      = 19;
    localparam int SPEED_BITS    = 20;
    localparam int RATE_BITS     = 18;
    localparam int CFG_DATA_BITS = 20;
    localparam int CFG_IDX_BITS  = 3;
    localparam int NUM_OFF       = 6;
    localparam int OFF_IDX_BITS  = 3;

    // distance arithmetic
    localparam int MAG_BITS   = OFF_BITS;
    localparam int SUMSQ_BITS = 2 * MAG_BITS + 2;
    localparam int ROOT_STEPS = SUMSQ_BITS / 2;
    localparam int ROOT_BITS  = ROOT_STEPS;
    localparam int PROD_BITS  = ROOT_BITS + RATE_BITS;
    localparam int STEP_BITS  = $clog2(ROOT_STEPS);

    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_DRAIN = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;  // dropped without a result

    localparam logic [CFG_IDX_BITS-1:0] CFG_LEFT_DX  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LEFT_DY  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LEFT_DZ  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RIGHT_DX = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RIGHT_DY = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RIGHT_DZ = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPEED    = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RATE     = 3'd7;

    localparam logic [OFF_BITS-1:0] OFF_RESET [NUM_OFF] = '{
        19'h7FC18, 19'd0, 19'd0, 19'd1000, 19'd0, 19'd0
    };
    localparam logic [SPEED_BITS-1:0] SPEED_RESET = 20'd343000;
    localparam logic [RATE_BITS-1:0]  RATE_RESET  = 18'd44100;

    typedef struct packed {
        logic cap;        // latch input transaction
        logic calc_init;  // begin delay computation, left channel
        logic sq_step;    // accumulate one squared offset
        logic root_step;  // one square root iteration
        logic mul;        // distance times sample rate
        logic chk;        // saturation check, divider setup
        logic div_step;   // one quotient bit
        logic store;      // write delay of current channel
        logic push_wr;    // store sample, bump fill count
        logic rd;         // ring read and flag evaluation
        logic load_out;   // load result register
    } t_cmd;

    typedef struct packed {
        logic drain_end;
        logic sq_last;
        logic root_last;
        logic sat;
        logic div_last;
        logic ch;
        logic out_free;
    } t_sts;

endpackage

### rtl/spdl_ctrl.sv
`timescale 1ns / 1ps
// Sequencing state machine: push/drain flow and the delay computation steps.
// Depends on spdl_pkg (t_cmd, t_sts, opcodes).
module spdl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [1:0]        i_op,
    input  spdl_pkg::t_sts    i_sts,
    output logic              o_ready,
    output spdl_pkg::t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PUSH,
        ST_DRAIN,
        ST_READ,
        ST_OUT,
        ST_SQ,
        ST_ROOT,
        ST_MUL,
        ST_CHK,
        ST_DIV,
        ST_STORE
    } t_state;

    t_state r_state, n_state;
    logic   r_ready;
    logic   w_acc;

    assign w_acc   = r_ready & i_valid;
    assign o_ready = r_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.cap = w_acc;
                if (w_acc) begin
                    case (i_op)
                        spdl_pkg::OP_PUSH:  n_state = ST_PUSH;
                        spdl_pkg::OP_DRAIN: n_state = ST_DRAIN;
                        spdl_pkg::OP_START: begin
                            o_cmd.calc_init = 1'b1;
                            n_state         = ST_SQ;
                        end
                        default:            n_state = ST_IDLE;
                    endcase
                end
            end
            ST_PUSH: begin
                o_cmd.push_wr = 1'b1;
                n_state       = ST_READ;
            end
            ST_DRAIN: begin
                n_state = i_sts.drain_end ? ST_IDLE : ST_READ;
            end
            ST_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_OUT;
            end
            ST_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            ST_SQ: begin
                o_cmd.sq_step = 1'b1;
                if (i_sts.sq_last) n_state = ST_ROOT;
            end
            ST_ROOT: begin
                o_cmd.root_step = 1'b1;
                if (i_sts.root_last) n_state = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_CHK;
            end
            ST_CHK: begin
                o_cmd.chk = 1'b1;
                n_state   = i_sts.sat ? ST_STORE : ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = ST_STORE;
            end
            ST_STORE: begin
                o_cmd.store = 1'b1;
                n_state     = i_sts.ch ? ST_IDLE : ST_SQ;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= (n_state == ST_IDLE);
        end
    end

endmodule

### rtl/spdl_dpath.sv
`timescale 1ns / 1ps
// Datapath: config registers, sample ring, counters, delay arithmetic
// (square/accumulate, bitwise root, multiply, restoring divide), result register.
// Depends on spdl_pkg.
module spdl_dpath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  spdl_pkg::t_cmd                       i_cmd,
    output spdl_pkg::t_sts                       o_sts,
    input  logic                                 i_cfg_wr_en,
    input  logic [spdl_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [spdl_pkg::CFG_DATA_BITS-1:0]   i_cfg_wdata,
    input  logic [1:0]                           i_op,
    input  logic signed [15:0]                   i_sample,
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    output logic signed [15:0]                   o_left,
    output logic signed [15:0]                   o_right,
    output logic                                 o_left_valid,
    output logic                                 o_right_valid,
    output logic                                 o_last,
    output logic                                 o_clip
);

    localparam int CW = spdl_pkg::CNT_BITS;
    localparam int DW = spdl_pkg::DELAY_BITS;
    localparam int AW = spdl_pkg::RING_AW;
    localparam int SW = spdl_pkg::SUMSQ_BITS;
    localparam int PW = spdl_pkg::PROD_BITS;
    localparam int TW = spdl_pkg::STEP_BITS;

    typedef struct packed {
        logic          hit;
        logic [AW-1:0] addr;
    } t_rd;

    // ring slot for output n at a given delay; hit is clear when the sample is not held
    function automatic t_rd rd_calc(input logic [CW-1:0] n, input logic [CW-1:0] sp,
                                    input logic [DW-1:0] dly);
        t_rd         res;
        logic [CW-1:0] m;
        logic [CW:0]   m_ext;
        m        = n - CW'(dly);
        m_ext    = {1'b0, m} + (CW+1)'(spdl_pkg::MAX_DELAY);
        res.hit  = (n >= CW'(dly)) && (m < sp) &&
                   !((sp > CW'(spdl_pkg::MAX_DELAY)) && (m_ext < {1'b0, sp}));
        res.addr = m[AW-1:0];
        return res;
    endfunction

    // configuration
    logic [spdl_pkg::OFF_BITS-1:0]   r_off [spdl_pkg::NUM_OFF];
    logic [spdl_pkg::SPEED_BITS-1:0] r_speed;
    logic [spdl_pkg::RATE_BITS-1:0]  r_rate;

    // buffer state
    logic signed [spdl_pkg::SAMPLE_BITS-1:0] r_ring [spdl_pkg::MAX_DELAY];
    logic [CW-1:0] r_sp, r_n;
    logic [DW-1:0] r_ldly, r_rdly;
    logic          r_clip;

    // captured input
    logic                                  r_push;
    logic signed [spdl_pkg::SAMPLE_BITS-1:0] r_sample;

    // read stage
    logic signed [spdl_pkg::SAMPLE_BITS-1:0] r_rd_l, r_rd_r;
    logic r_hit_l, r_hit_r, r_lv, r_rv, r_last;

    // delay arithmetic
    logic          r_ch;
    logic [TW-1:0] r_cnt;
    logic [SW-1:0] r_rem, r_res, r_bit;
    logic [PW-1:0] r_prod, r_dvs;
    logic [DW-1:0] r_q;
    logic          r_sat;

    // result register
    logic                    r_out_valid;
    logic signed [15:0]      r_out_l, r_out_r;
    logic                    r_out_lv, r_out_rv, r_out_last, r_out_clip;

    logic [spdl_pkg::OFF_IDX_BITS-1:0] w_off_idx;
    logic [spdl_pkg::OFF_BITS-1:0]     w_raw;
    logic [spdl_pkg::MAG_BITS-1:0]     w_mag;
    logic [2*spdl_pkg::MAG_BITS-1:0]   w_sq;
    logic [SW-1:0]                     w_trial;
    logic [PW:0]                       w_lim;
    logic [DW-1:0]                     w_maxd;
    logic [CW:0]                       w_end;
    t_rd                               w_rl, w_rr;
    logic [SW-1:0]                     w_bit_init;

    assign w_bit_init = SW'(1) << (SW - 2);
    assign w_off_idx  = spdl_pkg::OFF_IDX_BITS'(r_cnt[1:0]) +
                        (r_ch ? spdl_pkg::OFF_IDX_BITS'(3) : '0);
    assign w_raw      = r_off[w_off_idx];
    assign w_mag      = w_raw[spdl_pkg::OFF_BITS-1] ? (~w_raw + 1'b1) : w_raw;
    assign w_sq       = w_mag * w_mag;
    assign w_trial    = r_res + r_bit;
    // zero speed also lands here: the limit is zero
    assign w_lim      = (PW+1)'(r_speed) << DW;
    assign w_maxd     = (r_ldly > r_rdly) ? r_ldly : r_rdly;
    assign w_end      = {1'b0, r_sp} + (CW+1)'(w_maxd);
    assign w_rl       = rd_calc(r_n, r_sp, r_ldly);
    assign w_rr       = rd_calc(r_n, r_sp, r_rdly);

    assign o_sts.drain_end = ({1'b0, r_n} >= w_end);
    assign o_sts.sq_last   = (r_cnt == TW'(2));
    assign o_sts.root_last = (r_cnt == TW'(spdl_pkg::ROOT_STEPS - 1));
    assign o_sts.sat       = ({1'b0, r_prod} >= w_lim);
    assign o_sts.div_last  = (r_cnt == TW'(DW - 1));
    assign o_sts.ch        = r_ch;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < spdl_pkg::NUM_OFF; i++) r_off[i] <= spdl_pkg::OFF_RESET[i];
            r_speed <= spdl_pkg::SPEED_RESET;
            r_rate  <= spdl_pkg::RATE_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index) inside
                [spdl_pkg::CFG_LEFT_DX:spdl_pkg::CFG_RIGHT_DZ]:
                    r_off[i_cfg_index] <= i_cfg_wdata[spdl_pkg::OFF_BITS-1:0];
                spdl_pkg::CFG_SPEED: r_speed <= i_cfg_wdata[spdl_pkg::SPEED_BITS-1:0];
                spdl_pkg::CFG_RATE:  r_rate  <= i_cfg_wdata[spdl_pkg::RATE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // sample ring: one write port, two read ports, registered reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.push_wr && (r_sp != '1)) r_ring[r_sp[AW-1:0]] <= r_sample;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_l <= r_ring[w_rl.addr];
            r_rd_r <= r_ring[w_rr.addr];
        end
    end

    // buffer counters, delays, clip flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp   <= '0;
            r_n    <= '0;
            r_ldly <= '0;
            r_rdly <= '0;
            r_clip <= 1'b0;
        end else begin
            if (i_cmd.calc_init) r_clip <= 1'b0;
            if (i_cmd.push_wr && (r_sp != '1)) r_sp <= r_sp + 1'b1;
            if (i_cmd.rd && (r_n != '1)) r_n <= r_n + 1'b1;
            if (i_cmd.store) begin
                if (r_sat) r_clip <= 1'b1;
                if (r_ch) begin
                    r_rdly <= r_sat ? DW'(spdl_pkg::MAX_DELAY - 1) : r_q;
                    r_sp   <= '0;
                    r_n    <= '0;
                end else begin
                    r_ldly <= r_sat ? DW'(spdl_pkg::MAX_DELAY - 1) : r_q;
                end
            end
        end
    end

    // captured input and read-stage flags
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_push   <= (i_op == spdl_pkg::OP_PUSH);
            r_sample <= i_sample;
        end
        if (i_cmd.rd) begin
            r_hit_l <= w_rl.hit;
            r_hit_r <= w_rr.hit;
            r_lv    <= r_push || ({1'b0, r_n} < ({1'b0, r_sp} + (CW+1)'(r_ldly)));
            r_rv    <= r_push || ({1'b0, r_n} < ({1'b0, r_sp} + (CW+1)'(r_rdly)));
            r_last  <= !r_push && (({1'b0, r_n} + 1'b1) == w_end);
        end
    end

    // step counter and channel select
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_cmd.calc_init) begin
                r_ch  <= 1'b0;
                r_cnt <= '0;
            end
            if (i_cmd.sq_step)   r_cnt <= o_sts.sq_last ? '0 : r_cnt + 1'b1;
            if (i_cmd.root_step) r_cnt <= o_sts.root_last ? '0 : r_cnt + 1'b1;
            if (i_cmd.chk)       r_cnt <= '0;
            if (i_cmd.div_step)  r_cnt <= r_cnt + 1'b1;
            if (i_cmd.store) begin
                r_ch  <= 1'b1;
                r_cnt <= '0;
            end
        end
    end

    // distance, scale, divide
    always_ff @(posedge i_clk) begin
        if (i_cmd.calc_init || (i_cmd.store && !r_ch)) begin
            r_rem <= '0;
            r_res <= '0;
            r_bit <= w_bit_init;
        end
        if (i_cmd.sq_step) r_rem <= r_rem + SW'(w_sq);
        if (i_cmd.root_step) begin
            if (r_rem >= w_trial) begin
                r_rem <= r_rem - w_trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (i_cmd.mul) r_prod <= r_res[spdl_pkg::ROOT_BITS-1:0] * r_rate;
        if (i_cmd.chk) begin
            r_sat <= o_sts.sat;
            r_dvs <= PW'(r_speed) << (DW - 1);
            r_q   <= '0;
        end
        if (i_cmd.div_step) begin
            if (r_prod >= r_dvs) begin
                r_prod <= r_prod - r_dvs;
                r_q    <= {r_q[DW-2:0], 1'b1};
            end else begin
                r_q    <= {r_q[DW-2:0], 1'b0};
            end
            r_dvs <= r_dvs >> 1;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_l    <= r_hit_l ? r_rd_l : '0;
            r_out_r    <= r_hit_r ? r_rd_r : '0;
            r_out_lv   <= r_lv;
            r_out_rv   <= r_rv;
            r_out_last <= r_last;
            r_out_clip <= r_clip;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_left        = r_out_l;
    assign o_right       = r_out_r;
    assign o_left_valid  = r_out_lv;
    assign o_right_valid = r_out_rv;
    assign o_last        = r_out_last;
    assign o_clip        = r_out_clip;

endmodule

### rtl/stereo_propagation_delay_line_top.sv
`timescale 1ns / 1ps
// Top level of the stereo propagation delay line.
// Depends on spdl_pkg, spdl_ctrl and spdl_dpath.
//
// Usage
//   Input stream: one transaction per item. Opcode push stores a source sample and
//   returns output n of both microphones; drain returns the next tail output (none
//   once both tails are done); start computes both delays from the configured
//   offsets, speed and sample rate and clears the buffer counters. Opcode 3 is dropped.
//   Output stream: one transaction per push and per productive drain.
//   Config port: write-only, one register per cycle, only while the block is idle.
// Sequence
//   Push: accept, ring write/count, dual ring read, result load. Drain: accept, end
//   check, dual ring read, result load; a drain past the end returns to idle after
//   its end check. Start: per channel 3 square/accumulate steps, 20 root iterations,
//   1 multiply, 1 check, up to 12 divide steps and 1 store. The ring port and these
//   iterations set the rate.
// Reset and stall
//   Synchronous reset clears counters, delays, clip flag and the output valid;
//   config registers return to defaults. Ring contents are not cleared (no sweep).
//   The result register frees the input side: a new item is taken while a result
//   waits, and the block holds in its load step only if a second result is ready.
module stereo_propagation_delay_line_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // slave stream; tdata: [1:0] opcode, [17:2] sample_in, [23:18] zero
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  logic [23:0]                           i_s_axis_tdata,
    // master stream; tdata: [15:0] left_sample, [31:16] right_sample
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    output logic [31:0]                           o_m_axis_tdata,
    output logic                                  o_m_axis_tlast,
    // tuser: [0] left_valid, [1] right_valid, [2] delay_clipped
    output logic [2:0]                            o_m_axis_tuser,
    // config write port
    input  logic                                  i_cfg_wr_en,
    input  logic [spdl_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [spdl_pkg::CFG_DATA_BITS-1:0]    i_cfg_wdata
);

    spdl_pkg::t_cmd w_cmd;
    spdl_pkg::t_sts w_sts;

    logic signed [15:0] w_left, w_right;
    logic               w_lv, w_rv, w_clip;

    // opcode and sample unpacked from the input transaction
    spdl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .i_op    (i_s_axis_tdata[1:0]),
        .i_sts   (w_sts),
        .o_ready (o_s_axis_tready),
        .o_cmd   (w_cmd)
    );

    spdl_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_op          (i_s_axis_tdata[1:0]),
        .i_sample      (i_s_axis_tdata[17:2]),
        .i_out_ready   (i_m_axis_tready),
        .o_out_valid   (o_m_axis_tvalid),
        .o_left        (w_left),
        .o_right       (w_right),
        .o_left_valid  (w_lv),
        .o_right_valid (w_rv),
        .o_last        (o_m_axis_tlast),
        .o_clip        (w_clip)
    );

    assign o_m_axis_tdata = {w_right, w_left};
    assign o_m_axis_tuser = {w_clip, w_rv, w_lv};

endmodule

### rtl/spdl_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the stereo propagation delay line, bound to the top level.
// Depends on spdl_pkg for the opcodes.
module spdl_chk (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_s_axis_tvalid,
    input logic                                  o_s_axis_tready,
    input logic [23:0]                           i_s_axis_tdata,
    input logic                                  o_m_axis_tvalid,
    input logic                                  i_m_axis_tready,
    input logic [31:0]                           o_m_axis_tdata,
    input logic                                  o_m_axis_tlast,
    input logic [2:0]                            o_m_axis_tuser
);

    // a pending result holds its payload until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
        (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("result changed while stalled");

    // reset empties the result register and closes the input
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_m_axis_tvalid && !o_s_axis_tready))
        else $error("outputs active after reset");

    // the final tail output lies inside the longer channel
    a_last_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast) |-> (o_m_axis_tuser[0] || o_m_axis_tuser[1]))
        else $error("last without a valid channel");

    // any real opcode keeps the block busy for at least the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready &&
         (i_s_axis_tdata[1:0] != spdl_pkg::OP_NONE)) |=>
        !o_s_axis_tready)
        else $error("ready right after accepting an item");

    // a new result never shows up in the cycle after an accept
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && !o_m_axis_tvalid) |=> !o_m_axis_tvalid)
        else $error("result too early");

endmodule

bind stereo_propagation_delay_line_top spdl_chk u_spdl_chk (.*);
